// ===== rtl/core/sgp_pkg.sv =====
`default_nettype none
package sgp_pkg;

   localparam int TIMER_WIDTH  = 16;
   localparam int NUM_BUTTONS  = 8;
   localparam int STEP_COUNT   = 2 + 2 * NUM_BUTTONS;
   localparam int LAST_STEP    = STEP_COUNT - 1;
   localparam int STEP_WIDTH   = $clog2(STEP_COUNT);
   localparam int KEY_IDX_WIDTH = $clog2(NUM_BUTTONS);

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [TIMER_WIDTH-1:0] READ_DELAY_RESET     = TIMER_WIDTH'(8);
   localparam logic [TIMER_WIDTH-1:0] CLOCK_INTERVAL_RESET = TIMER_WIDTH'(2);

   typedef enum logic [1:0] {
      OP_TICK         = 2'd0,
      OP_READ_PRESSED = 2'd1,
      OP_READ_HELD    = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LISTEN_ENABLE  = 2'd0,
      CSR_READ_DELAY     = 2'd1,
      CSR_CLOCK_INTERVAL = 2'd2
   } csr_index_type;

   typedef logic [NUM_BUTTONS-1:0] keys_type;

   // poller status after an item's update
   typedef struct packed {
      logic     latch_strobe;
      logic     clock_strobe;
      keys_type held_keys;
      keys_type pressed_keys;
      logic     keys_valid;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/sgp_if.sv =====
`default_nettype none
interface sgp_req_if;
   import sgp_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic       data_pin;

   modport source (output valid, output opcode, output data_pin, input ready);
   modport sink (input valid, input opcode, input data_pin, output ready);
endinterface

interface sgp_rsp_if;
   import sgp_pkg::*;
   logic     valid;
   logic     ready;
   logic     latch_strobe;
   logic     clock_strobe;
   keys_type held_keys;
   keys_type pressed_keys;
   logic     keys_valid;

   modport source (output valid, output latch_strobe, output clock_strobe,
                   output held_keys, output pressed_keys, output keys_valid,
                   input ready);
   modport sink (input valid, input latch_strobe, input clock_strobe,
                 input held_keys, input pressed_keys, input keys_valid,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sgp_sequencer.sv =====
`default_nettype none
module sgp_sequencer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [sgp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [sgp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  wire logic                                 beat,
   input  wire logic [1:0]                           opcode,
   input  wire logic                                 data_pin,
   output sgp_pkg::status_type                       status
);
   import sgp_pkg::*;

   logic                   listen_ff, listen_in;
   logic [TIMER_WIDTH-1:0] read_delay_ff, read_delay_in;
   logic [TIMER_WIDTH-1:0] clock_interval_ff, clock_interval_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   keys_type               shift_ff, shift_in;
   keys_type               prev_ff, prev_in;
   keys_type               held_ff, held_in;
   keys_type               accum_ff, accum_in;
   logic [TIMER_WIDTH-1:0] counter_ff, counter_in;
   logic [TIMER_WIDTH-1:0] compare_ff, compare_in;
   logic                   ready_ff, ready_in;
   logic                   latch_ff, latch_in;
   logic                   clk_ff, clk_in;
   keys_type               pressed;

   always_comb begin
      logic [KEY_IDX_WIDTH-1:0] bit_idx;
      keys_type                 sampled;

      listen_in         = listen_ff;
      read_delay_in     = read_delay_ff;
      clock_interval_in = clock_interval_ff;
      step_in           = step_ff;
      shift_in          = shift_ff;
      prev_in           = prev_ff;
      held_in           = held_ff;
      accum_in          = accum_ff;
      counter_in        = counter_ff;
      compare_in        = compare_ff;
      ready_in          = ready_ff;
      latch_in          = latch_ff;
      clk_in            = clk_ff;
      pressed           = '0;
      bit_idx           = KEY_IDX_WIDTH'(step_ff[STEP_WIDTH-1:1] - 1'b1);
      sampled           = shift_ff | (keys_type'(data_pin) << bit_idx);

      if (csr_we) begin
         case (csr_index)
            CSR_LISTEN_ENABLE: begin
               listen_in = csr_wdata[0];
               // enabling restarts the pause before the next read
               if (csr_wdata[0]) begin
                  counter_in = '0;
                  compare_in = read_delay_ff;
               end
            end
            CSR_READ_DELAY:     read_delay_in = TIMER_WIDTH'(csr_wdata);
            CSR_CLOCK_INTERVAL: clock_interval_in = TIMER_WIDTH'(csr_wdata);
            default: ;
         endcase
      end

      if (beat) begin
         case (opcode)
            OP_TICK: begin
               if (listen_ff) begin
                  if (counter_ff == compare_ff) begin
                     counter_in = '0;
                     if (step_ff == '0) begin
                        latch_in = 1'b1;
                        shift_in = '0;
                     end else if (step_ff == STEP_WIDTH'(1)) begin
                        latch_in = 1'b0;
                     end else if (step_ff <= STEP_WIDTH'(LAST_STEP)) begin
                        if (!step_ff[0]) begin
                           clk_in = 1'b1;
                        end else begin
                           shift_in = sampled;
                           clk_in   = 1'b0;
                           if (step_ff == STEP_WIDTH'(LAST_STEP)) begin
                              held_in  = sampled;
                              ready_in = 1'b1;
                              accum_in = accum_ff | (sampled & ~prev_ff);
                              prev_in  = sampled;
                           end
                        end
                     end
                     // advance; wrap reloads read_delay, step 0 clock_interval
                     if (step_ff >= STEP_WIDTH'(LAST_STEP)) begin
                        step_in    = '0;
                        compare_in = read_delay_ff;
                     end else begin
                        step_in = step_ff + 1'b1;
                        if (step_ff == '0) begin
                           compare_in = clock_interval_ff;
                        end
                     end
                  end else begin
                     counter_in = counter_ff + 1'b1;
                  end
               end
            end
            OP_READ_PRESSED: begin
               pressed  = accum_ff;
               accum_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff         <= 1'b0;
         read_delay_ff     <= READ_DELAY_RESET;
         clock_interval_ff <= CLOCK_INTERVAL_RESET;
         step_ff           <= '0;
         shift_ff          <= '0;
         prev_ff           <= '0;
         held_ff           <= '0;
         accum_ff          <= '0;
         counter_ff        <= '0;
         compare_ff        <= READ_DELAY_RESET;
         ready_ff          <= 1'b0;
         latch_ff          <= 1'b0;
         clk_ff            <= 1'b0;
      end else begin
         listen_ff         <= listen_in;
         read_delay_ff     <= read_delay_in;
         clock_interval_ff <= clock_interval_in;
         step_ff           <= step_in;
         shift_ff          <= shift_in;
         prev_ff           <= prev_in;
         held_ff           <= held_in;
         accum_ff          <= accum_in;
         counter_ff        <= counter_in;
         compare_ff        <= compare_in;
         ready_ff          <= ready_in;
         latch_ff          <= latch_in;
         clk_ff            <= clk_in;
      end
   end

   assign status = '{latch_strobe: latch_in,
                     clock_strobe: clk_in,
                     held_keys:    held_in,
                     pressed_keys: pressed,
                     keys_valid:   ready_in};

endmodule
`default_nettype wire

// ===== rtl/core/serial_gamepad_poller_top.sv =====
// Serial gamepad poller.
// req_bus carries one item per beat: opcode (tick, read-and-clear pressed keys,
// read held keys) and the sampled controller data pin. While listen_enable is set,
// each tick advances the interval counter and, when it meets the compare value,
// runs one step of the latch/clock/sample sequence. rsp_bus returns exactly one
// result per item: latch and clock line levels, held keys, pressed keys (opcode
// read-pressed only) and the ready flag, all taken after the item's update.
// The result is registered and valid in the cycle after the request beat.
// Throughput: one item per cycle while rsp_bus takes results; the poller state
// updates in the accepting cycle, and a single output register holds the result.
// req_bus.ready is high while the output register is empty or is being emptied
// in the same cycle, so when rsp_bus stalls at most one result waits. csr_we,
// csr_index and csr_wdata write listen_enable, read_delay and clock_interval;
// write them only while no item is in flight. Reset (synchronous, active high)
// stops polling, restores read_delay 8, clock_interval 2, clears keys and flags.
`default_nettype none
module serial_gamepad_poller_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   sgp_req_if.sink                                  req_bus,
   sgp_rsp_if.source                                rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [sgp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sgp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import sgp_pkg::*;

   logic       rsp_valid_ff;
   status_type rsp_data_ff;
   status_type status;
   logic       req_beat;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_beat      = req_bus.valid && req_bus.ready;

   sgp_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .beat      (req_beat),
      .opcode    (req_bus.opcode),
      .data_pin  (req_bus.data_pin),
      .status    (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: load on every accepted request
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= status;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.latch_strobe = rsp_data_ff.latch_strobe;
   assign rsp_bus.clock_strobe = rsp_data_ff.clock_strobe;
   assign rsp_bus.held_keys    = rsp_data_ff.held_keys;
   assign rsp_bus.pressed_keys = rsp_data_ff.pressed_keys;
   assign rsp_bus.keys_valid   = rsp_data_ff.keys_valid;

endmodule
`default_nettype wire

// ===== tb/serial_gamepad_poller_top_tb.sv =====
module serial_gamepad_poller_top_tb;
   import sgp_pkg::*;

   localparam logic [1:0]                 OP_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int                         HOLD_CYCLES = 64;

   typedef struct packed {
      logic [1:0] opcode;
      logic       data_pin;
   } poll_item_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   sgp_req_if req_bus ();
   sgp_rsp_if rsp_bus ();

   serial_gamepad_poller_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   poll_item_type pending_items[$];
   status_type    expected_status[$];
   int            mismatch_count = 0;
   int            send_idle_pct = 28;
   int            recv_idle_pct = 86;
   bit            hold_request = 1'b0;
   logic          rsp_hold = 1'b0;

   // shadow copy of the poller registers and state
   logic                   shadow_listen;
   logic [TIMER_WIDTH-1:0] shadow_read_delay;
   logic [TIMER_WIDTH-1:0] shadow_clock_interval;
   logic [STEP_WIDTH-1:0]  shadow_step;
   keys_type               shadow_shift;
   keys_type               shadow_previous;
   keys_type               shadow_held;
   keys_type               shadow_accum;
   logic [TIMER_WIDTH-1:0] shadow_count;
   logic [TIMER_WIDTH-1:0] shadow_compare;
   logic                   shadow_ready;
   logic                   shadow_latch;
   logic                   shadow_clock_line;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic reset_shadow();
      shadow_listen         = 1'b0;
      shadow_read_delay     = READ_DELAY_RESET;
      shadow_clock_interval = CLOCK_INTERVAL_RESET;
      shadow_step           = '0;
      shadow_shift          = '0;
      shadow_previous       = '0;
      shadow_held           = '0;
      shadow_accum          = '0;
      shadow_count          = '0;
      shadow_compare        = READ_DELAY_RESET;
      shadow_ready          = 1'b0;
      shadow_latch          = 1'b0;
      shadow_clock_line     = 1'b0;
   endtask

   // advance the shadow poller by one item and return the status it reports
   function automatic status_type poll_status_after(logic [1:0] opcode, logic pin);
      status_type result;
      keys_type   pressed;
      pressed = '0;
      if (opcode == OP_TICK) begin
         if (shadow_listen) begin
            if (shadow_count == shadow_compare) begin
               shadow_count = '0;
               if (shadow_step == 0) begin
                  shadow_latch = 1'b1;
                  shadow_shift = '0;
               end else if (shadow_step == 1) begin
                  shadow_latch = 1'b0;
               end else if (shadow_step <= LAST_STEP) begin
                  if (!shadow_step[0]) begin
                     shadow_clock_line = 1'b1;
                  end else begin
                     shadow_shift = shadow_shift | (keys_type'(pin) << ((shadow_step - 3) >> 1));
                     shadow_clock_line = 1'b0;
                     if (shadow_step == LAST_STEP) begin
                        shadow_held     = shadow_shift;
                        shadow_ready    = 1'b1;
                        shadow_accum    = shadow_accum | (shadow_shift & ~shadow_previous);
                        shadow_previous = shadow_shift;
                     end
                  end
               end
               shadow_step = (shadow_step >= LAST_STEP) ? '0 : shadow_step + 1'b1;
               if (shadow_step == 0)
                  shadow_compare = shadow_read_delay;
               else if (shadow_step == 1)
                  shadow_compare = shadow_clock_interval;
            end else begin
               shadow_count = shadow_count + 1'b1;
            end
         end
      end else if (opcode == OP_READ_PRESSED) begin
         pressed      = shadow_accum;
         shadow_accum = '0;
      end
      result.latch_strobe = shadow_latch;
      result.clock_strobe = shadow_clock_line;
      result.held_keys    = shadow_held;
      result.pressed_keys = pressed;
      result.keys_valid   = shadow_ready;
      return result;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_LISTEN_ENABLE: begin
            shadow_listen = value[0];
            if (value[0]) begin
               shadow_compare = shadow_read_delay;
               shadow_count   = '0;
            end
         end
         CSR_READ_DELAY:     shadow_read_delay = value;
         CSR_CLOCK_INTERVAL: shadow_clock_interval = value;
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < 40)
         $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatch_count++;
   endtask

   task automatic push_item(input logic [1:0] opcode, input logic pin);
      poll_item_type item;
      item.opcode   = opcode;
      item.data_pin = pin;
      pending_items.push_back(item);
   endtask

   function automatic logic [1:0] random_opcode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return OP_TICK;
      if (roll < 88) return OP_READ_PRESSED;
      if (roll < 96) return OP_READ_HELD;
      return OP_UNUSED;
   endfunction

   // look between edges so that the driver's updates have settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // request driver: hold the beat until accepted, then maybe idle
   always @(posedge clock) begin : request_driver
      poll_item_type item;
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.opcode   <= OP_TICK;
         req_bus.data_pin <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_status.push_back(poll_status_after(req_bus.opcode, req_bus.data_pin));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_items.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.opcode   <= item.opcode;
               req_bus.data_pin <= item.data_pin;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_receiver
      rsp_bus.ready <= (reset || rsp_hold) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : result_check
      status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("result beat with no item pending", 8'h0, 8'h0);
         end else begin
            want = expected_status.pop_front();
            if (rsp_bus.latch_strobe !== want.latch_strobe)
               report_mismatch("latch_strobe", 8'(rsp_bus.latch_strobe),
                               8'(want.latch_strobe));
            if (rsp_bus.clock_strobe !== want.clock_strobe)
               report_mismatch("clock_strobe", 8'(rsp_bus.clock_strobe),
                               8'(want.clock_strobe));
            if (rsp_bus.held_keys !== want.held_keys)
               report_mismatch("held_keys", rsp_bus.held_keys, want.held_keys);
            if (rsp_bus.pressed_keys !== want.pressed_keys)
               report_mismatch("pressed_keys", rsp_bus.pressed_keys, want.pressed_keys);
            if (rsp_bus.keys_valid !== want.keys_valid)
               report_mismatch("keys_valid", 8'(rsp_bus.keys_valid), 8'(want.keys_valid));
         end
      end
   end

   // long receiver stall so the output register fills and the input backs up
   initial begin : rsp_pressure
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #3600000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int item_count;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      reset_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // polling off after reset: ticks do nothing, reads report reset state
      push_item(OP_TICK, 1'b0);
      push_item(OP_TICK, 1'b1);
      push_item(OP_READ_PRESSED, 1'b0);
      push_item(OP_READ_HELD, 1'b1);
      push_item(OP_UNUSED, 1'b1);
      wait_drained();

      // fastest timing: one full read of all-pressed keys in 18 ticks
      write_csr(CSR_READ_DELAY, 16'h0000);
      write_csr(CSR_CLOCK_INTERVAL, 16'h0000);
      write_csr(CSR_LISTEN_ENABLE, 16'h0001);
      for (int i = 0; i < 18; i++)
         push_item(OP_TICK, 1'b1);
      push_item(OP_READ_HELD, 1'b0);
      push_item(OP_READ_PRESSED, 1'b0);
      push_item(OP_READ_PRESSED, 1'b1);
      push_item(OP_UNUSED, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 9; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 86;
         end else if (phase < 6) begin
            send_idle_pct = 86;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(1))
            write_csr(CSR_LISTEN_ENABLE, 16'(phase != 7));
         if (phase == 4) begin
            write_csr(CSR_READ_DELAY, 16'hFFFF);
            write_csr(CSR_CLOCK_INTERVAL, 16'hFFFF);
         end else begin
            write_csr(CSR_READ_DELAY, 16'($urandom_range(3)));
            write_csr(CSR_CLOCK_INTERVAL, 16'($urandom_range(2)));
         end
         if (phase == 2)
            write_csr(CSR_UNUSED, 16'($urandom));
         write_csr(CSR_LISTEN_ENABLE, 16'(phase != 7));
         item_count = (phase == 4 || phase == 7) ? 40 : 180;
         for (int i = 0; i < item_count; i++)
            push_item(random_opcode(), 1'($urandom_range(1)));
         if (phase == 6)
            hold_request = 1'b1;
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
